[hw/rtl/assert_macros.svh]
// Assertion macros shared by the value noise height generator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked property, masked while reset is high
`define VNG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also live during reset
`define VNG_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VNG_ASSERT(lbl, clk, rst, prop, msg)
`define VNG_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/vng_pkg.sv]
// Shared types, constants and the cosine weight function
`timescale 1ns / 1ps
package vng_pkg;

  typedef struct packed {
    logic valid;
    logic sign_x;
    logic sign_z;
  } ctl_t;

  typedef enum logic [2:0] {
    REG_SEED    = 3'd0,
    REG_OCTAVES = 3'd1,
    REG_GAIN    = 3'd2,
    REG_SMOOTH  = 3'd3,
    REG_OFFSET  = 3'd4,
    REG_ROUGH   = 3'd5
  } reg_idx_t;

  localparam logic [31:0] HASH_Z_MUL = 32'd57;
  localparam int          HASH_SHIFT = 13;
  localparam logic [31:0] HASH_MUL   = 32'd60493;
  localparam logic [31:0] HASH_ADD1  = 32'd19990303;
  localparam logic [31:0] HASH_ADD2  = 32'd1376312589;
  localparam logic [31:0] HASH_MASK  = 32'h7fffffff;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // Q1.16 weight (1 - cos(pi*idx/2^bits))/2, Taylor series in Q30.
  // Only called with constant arguments.
  function automatic logic [16:0] cos_weight(input int unsigned idx,
                                             input int unsigned bits);
    longint unsigned theta;
    longint unsigned th2;
    longint unsigned term;
    longint unsigned w;
    longint          c;
    longint          diff;
    int unsigned     half;
    int unsigned     j;
    half = 32'd1 << (bits - 1);
    j = (idx > half) ? ((32'd1 << bits) - idx) : idx;
    theta = (PI_Q30 * longint'(j)) >> bits;
    th2 = (theta * theta) >> 30;
    term = ONE_Q30;
    c = longint'(ONE_Q30);
    term = ((term * th2) >> 30) / 2;   c = c - longint'(term);
    term = ((term * th2) >> 30) / 12;  c = c + longint'(term);
    term = ((term * th2) >> 30) / 30;  c = c - longint'(term);
    term = ((term * th2) >> 30) / 56;  c = c + longint'(term);
    term = ((term * th2) >> 30) / 90;  c = c - longint'(term);
    term = ((term * th2) >> 30) / 132; c = c + longint'(term);
    term = ((term * th2) >> 30) / 182; c = c - longint'(term);
    term = ((term * th2) >> 30) / 240; c = c + longint'(term);
    term = ((term * th2) >> 30) / 306; c = c - longint'(term);
    term = ((term * th2) >> 30) / 380; c = c + longint'(term);
    diff = longint'(ONE_Q30) - c;
    if (diff < 0) diff = 0;
    w = (longint'(diff) + 64'd16384) >> 15;
    if (w > 64'd32768) w = 64'd32768;
    if (idx > half) return 17'(64'd65536 - w);
    return 17'(w);
  endfunction

endpackage

[hw/rtl/vng_in_if.sv]
// Coordinate request channel
`timescale 1ns / 1ps
interface vng_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         local_x;
  logic [3:0]         local_z;
  logic signed [20:0] chunk_x;
  logic signed [20:0] chunk_z;

  modport source (output valid, local_x, local_z, chunk_x, chunk_z, input ready);
  modport sink (input valid, local_x, local_z, chunk_x, chunk_z, output ready);
endinterface

[hw/rtl/vng_out_if.sv]
// Height result channel
`timescale 1ns / 1ps
interface vng_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] height_q8;

  modport source (output valid, height_q8, input ready);
  modport sink (input valid, height_q8, output ready);
endinterface

[hw/rtl/value_noise_height_generator_core.sv]
// Top level: value noise terrain height generator
//
//   channel   dir  fields                               handshake
//   coord     in   local_x local_z chunk_x chunk_z      valid/ready
//   result    out  height_q8                            valid/ready
//   cfg       in   cfg_index cfg_data                   cfg_we, no wait
//
// One coordinate per cycle when result is not stalled. The bit-per-stage
// divider yields a QW-bit quotient, QW = 37 + clog2(chunk size)
// + MAX_OCTAVES - 1. A two-entry output buffer takes the last stage, so
// coord.ready depends only on its fill. Reset clears valid bits and config.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module value_noise_height_generator_core #(
  parameter int CHUNK_X_SIZE      = 16,
  parameter int CHUNK_Z_SIZE      = 16,
  parameter int MAX_OCTAVES       = 16,
  parameter int COSINE_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  vng_in_if.sink      coord,
  vng_out_if.source   result
);
  localparam int NCELL = (MAX_OCTAVES > 1) ? MAX_OCTAVES - 1 : 1;
  localparam int MAXC  = (CHUNK_X_SIZE > CHUNK_Z_SIZE) ? CHUNK_X_SIZE : CHUNK_Z_SIZE;
  localparam int MAGW  = 21 + $clog2(MAXC);
  localparam int WW    = MAGW + 1;
  localparam int SH    = 16 + NCELL;
  localparam int QW    = MAGW + SH;
  localparam int SUMW  = 19 + $clog2(NCELL + 1);
  localparam int AW    = SUMW + 7;
  localparam int PW    = AW + 17;
  localparam int YW    = PW - 8;
  localparam logic [31:0] CLAMP = 32'd1761607680;          // 105 * 2^24
  localparam logic [63:0] RECIP = (64'd1 << 38) / 105;

  // configuration
  logic [31:0]        seed;
  logic [4:0]         octave_count;
  logic [15:0]        height_gain;
  logic [15:0]        smoothness;
  logic signed [15:0] height_offset;
  logic [15:0]        roughness_q16;
  logic [15:0]        sm_eff;
  logic [5:0]         oct_lim, oct_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed          <= 32'd0;
      octave_count  <= 5'd7;
      height_gain   <= 16'd200;
      smoothness    <= 16'd128;
      height_offset <= 16'sd3;
      roughness_q16 <= 16'd34734;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vng_pkg::REG_SEED:    seed          <= cfg_data;
        vng_pkg::REG_OCTAVES: octave_count  <= cfg_data[4:0];
        vng_pkg::REG_GAIN:    height_gain   <= cfg_data[15:0];
        vng_pkg::REG_SMOOTH:  smoothness    <= cfg_data[15:0];
        vng_pkg::REG_OFFSET:  height_offset <= $signed(cfg_data[15:0]);
        vng_pkg::REG_ROUGH:   roughness_q16 <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign sm_eff   = (smoothness == 16'd0) ? 16'd1 : smoothness;
  assign oct_lim  = ({1'b0, octave_count} > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES)
                                                             : {1'b0, octave_count};
  assign oct_used = (oct_lim == 6'd0) ? 6'd0 : oct_lim - 6'd1;

  // flow control
  logic [1:0]         fcnt;
  logic               adv, push, pop;
  logic signed [23:0] fd0, fd1, push_data;

  assign adv         = (fcnt != 2'd2);
  assign coord.ready = adv;

  // input stage: world position, sign and magnitude
  logic signed [WW-1:0] wx, wz;
  logic [WW-1:0]        ux, uz, ax, az;
  vng_pkg::ctl_t        ctl0;
  logic [MAGW-1:0]      magx0, magz0;

  assign wx = WW'(coord.chunk_x) * $signed(WW'(CHUNK_X_SIZE)) + $signed(WW'(coord.local_x));
  assign wz = WW'(coord.chunk_z) * $signed(WW'(CHUNK_Z_SIZE)) + $signed(WW'(coord.local_z));
  assign ux = wx;
  assign uz = wz;
  assign ax = wx[WW-1] ? (~ux + WW'(1)) : ux;
  assign az = wz[WW-1] ? (~uz + WW'(1)) : uz;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0 <= '0;
    end else if (adv) begin
      ctl0 <= '{valid: coord.valid, sign_x: wx[WW-1], sign_z: wz[WW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      magx0 <= ax[MAGW-1:0];
      magz0 <= az[MAGW-1:0];
    end
  end

  // divider chain: Q = |w| * 2^SH / smoothness
  vng_pkg::ctl_t   dctl [QW+1];
  logic [MAGW-1:0] dmx [QW+1];
  logic [MAGW-1:0] dmz [QW+1];
  logic [15:0]     drx [QW+1];
  logic [15:0]     drz [QW+1];
  logic [QW-1:0]   dqx [QW+1];
  logic [QW-1:0]   dqz [QW+1];

  assign dctl[0] = ctl0;
  assign dmx[0]  = magx0;
  assign dmz[0]  = magz0;
  assign drx[0]  = 16'd0;
  assign drz[0]  = 16'd0;
  assign dqx[0]  = '0;
  assign dqz[0]  = '0;

  generate
    for (genvar s = 0; s < QW; s++) begin : g_div
      vng_div_cell #(.MAGW(MAGW), .SH(SH), .STEP(s)) u_div (
        .clk(clk), .rst(rst), .adv(adv), .sm(sm_eff),
        .ctl_in(dctl[s]), .mag_x_in(dmx[s]), .mag_z_in(dmz[s]),
        .rem_x_in(drx[s]), .rem_z_in(drz[s]), .quo_x_in(dqx[s]), .quo_z_in(dqz[s]),
        .ctl_out(dctl[s+1]), .mag_x_out(dmx[s+1]), .mag_z_out(dmz[s+1]),
        .rem_x_out(drx[s+1]), .rem_z_out(drz[s+1]),
        .quo_x_out(dqx[s+1]), .quo_z_out(dqz[s+1])
      );
    end
  endgenerate

  // octave chain
  vng_pkg::ctl_t          octl [NCELL+1];
  logic [QW-1:0]          oqx [NCELL+1];
  logic [QW-1:0]          oqz [NCELL+1];
  logic signed [SUMW-1:0] osum [NCELL+1];
  logic [16:0]            oamp [NCELL+1];

  assign octl[0] = dctl[QW];
  assign oqx[0]  = dqx[QW];
  assign oqz[0]  = dqz[QW];
  assign osum[0] = '0;
  assign oamp[0] = 17'd65536;

  generate
    for (genvar a = 0; a < NCELL; a++) begin : g_oct
      vng_oct_cell #(.QW(QW), .SUMW(SUMW), .NCELL(NCELL), .OCT(a),
                     .TBITS(COSINE_TABLE_BITS)) u_oct (
        .clk(clk), .rst(rst), .adv(adv), .active(6'(a) < oct_used),
        .seed(seed), .roughness_q16(roughness_q16),
        .ctl_in(octl[a]), .qx_in(oqx[a]), .qz_in(oqz[a]),
        .sum_in(osum[a]), .amp_in(oamp[a]),
        .ctl_out(octl[a+1]), .qx_out(oqx[a+1]), .qz_out(oqz[a+1]),
        .sum_out(osum[a+1]), .amp_out(oamp[a+1])
      );
    end
  endgenerate

  // scale: floor((sum*50 + 8257536)*gain / 26880) + 256*offset, saturated
  logic [4:0]            fv;
  logic signed [AW-1:0]  f1_a;
  logic signed [PW-1:0]  f2_p;
  logic signed [YW-1:0]  y;
  logic [31:0]           u_next, f3_u, f4_u, f5_u;
  logic [63:0]           f4_prod;
  logic [25:0]           f5_q;
  logic [31:0]           rem105;
  logic [25:0]           qc;
  logic signed [27:0]    hs;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (adv) begin
      fv <= {fv[3:0], octl[NCELL].valid};
    end
  end

  // clamping keeps the quotient in 26 bits without changing the saturated result
  always_comb begin
    y = YW'(f2_p >>> 8);
    if (y > $signed(YW'(CLAMP)))
      u_next = CLAMP + CLAMP;
    else if (y < -$signed(YW'(CLAMP)))
      u_next = 32'd0;
    else
      u_next = 32'(y) + CLAMP;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_a    <= AW'(osum[NCELL]) * $signed(AW'(50)) + $signed(AW'(8257536));
      f2_p    <= PW'(f1_a) * $signed({1'b0, height_gain});
      f3_u    <= u_next;
      f4_prod <= 64'(f3_u) * RECIP;
      f4_u    <= f3_u;
      f5_q    <= f4_prod[63:38];
      f5_u    <= f4_u;
    end
  end

  // reciprocal estimate is at most one low
  always_comb begin
    rem105 = f5_u - 32'(f5_q) * 32'd105;
    qc = (rem105 >= 32'd105) ? f5_q + 26'd1 : f5_q;
    hs = $signed(28'(qc)) - $signed(28'(1 << 24)) + 28'($signed({height_offset, 8'b0}));
    if (hs > 28'sd8388607)
      push_data = 24'sd8388607;
    else if (hs < -28'sd8388608)
      push_data = -24'sd8388608;
    else
      push_data = 24'(hs);
  end

  // two-entry output buffer
  assign push = adv && fv[4];
  assign pop  = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= 2'd0;
    end else begin
      fcnt <= fcnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (fcnt == 2'd2) begin
        fd0 <= fd1;
      end else if (push) begin
        fd0 <= push_data;
      end
    end else if (push) begin
      if (fcnt == 2'd0) fd0 <= push_data;
      else fd1 <= push_data;
    end
  end

  assign result.valid     = (fcnt != 2'd0);
  assign result.height_q8 = fd0;

  `VNG_ASSERT_RST(a_rst_empty, clk, rst |=> !result.valid, "output valid right after reset")
  `VNG_ASSERT(a_no_overrun, clk, rst, !(push && !pop && fcnt == 2'd2), "push into full buffer")
  `VNG_ASSERT(a_drain, clk, rst, (pop && !push && fcnt == 2'd1) |=> !result.valid, "stale result")
  `VNG_ASSERT(a_take, clk, rst, (coord.valid && coord.ready) |=> ctl0.valid, "request lost")
endmodule

[hw/rtl/vng_div_cell.sv]
// One quotient bit of the pipelined coordinate divider (x and z lanes)
`timescale 1ns / 1ps
module vng_div_cell #(
  parameter int MAGW = 25,
  parameter int SH   = 31,
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic [15:0]           sm,
  input  vng_pkg::ctl_t         ctl_in,
  input  logic [MAGW-1:0]       mag_x_in,
  input  logic [MAGW-1:0]       mag_z_in,
  input  logic [15:0]           rem_x_in,
  input  logic [15:0]           rem_z_in,
  input  logic [MAGW+SH-1:0]    quo_x_in,
  input  logic [MAGW+SH-1:0]    quo_z_in,
  output vng_pkg::ctl_t         ctl_out,
  output logic [MAGW-1:0]       mag_x_out,
  output logic [MAGW-1:0]       mag_z_out,
  output logic [15:0]           rem_x_out,
  output logic [15:0]           rem_z_out,
  output logic [MAGW+SH-1:0]    quo_x_out,
  output logic [MAGW+SH-1:0]    quo_z_out
);
  localparam int QW  = MAGW + SH;
  localparam int BIT = QW - 1 - STEP;

  logic              bx, bz;
  logic [16:0]       rx, rz, rx_sub, rz_sub;
  logic              gex, gez;
  logic [QW-1:0]     qx_next, qz_next;

  // dividend is mag followed by SH zero bits
  generate
    if (BIT >= SH) begin : g_mag_bit
      assign bx = mag_x_in[BIT-SH];
      assign bz = mag_z_in[BIT-SH];
    end else begin : g_zero_bit
      assign bx = 1'b0;
      assign bz = 1'b0;
    end
  endgenerate

  always_comb begin
    rx = {rem_x_in, bx};
    rz = {rem_z_in, bz};
    gex = rx >= {1'b0, sm};
    gez = rz >= {1'b0, sm};
    rx_sub = gex ? (rx - {1'b0, sm}) : rx;
    rz_sub = gez ? (rz - {1'b0, sm}) : rz;
    qx_next = quo_x_in;
    qz_next = quo_z_in;
    qx_next[BIT] = gex;
    qz_next[BIT] = gez;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_x_out <= mag_x_in;
      mag_z_out <= mag_z_in;
      rem_x_out <= rx_sub[15:0];
      rem_z_out <= rz_sub[15:0];
      quo_x_out <= qx_next;
      quo_z_out <= qz_next;
    end
  end
endmodule

[hw/rtl/vng_oct_cell.sv]
// One octave of the fractal sum: hash, cosine blend, weighted accumulate
`timescale 1ns / 1ps
module vng_oct_cell #(
  parameter int QW    = 56,
  parameter int SUMW  = 23,
  parameter int NCELL = 15,
  parameter int OCT   = 0,
  parameter int TBITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   active,
  input  logic [31:0]            seed,
  input  logic [15:0]            roughness_q16,
  input  vng_pkg::ctl_t          ctl_in,
  input  logic [QW-1:0]          qx_in,
  input  logic [QW-1:0]          qz_in,
  input  logic signed [SUMW-1:0] sum_in,
  input  logic [16:0]            amp_in,
  output vng_pkg::ctl_t          ctl_out,
  output logic [QW-1:0]          qx_out,
  output logic [QW-1:0]          qz_out,
  output logic signed [SUMW-1:0] sum_out,
  output logic [16:0]            amp_out
);
  localparam int LAT = 7;
  localparam int TN  = 1 << TBITS;
  localparam int EW  = QW + 32;
  localparam int POS = NCELL - OCT;

  logic [16:0] wtab [TN];

  generate
    for (genvar i = 0; i < TN; i++) begin : g_tab
      assign wtab[i] = vng_pkg::cos_weight(i, TBITS);
    end
  endgenerate

  logic [EW-1:0]      qxe, qze;
  logic [31:0]        cxm, czm, cx, cz, base;
  logic [31:0]        nb [4];
  logic [31:0]        nh [4];
  logic [15:0]        fx, fz;

  vng_pkg::ctl_t      ctl_p [LAT];
  logic [QW-1:0]      qx_p [LAT];
  logic [QW-1:0]      qz_p [LAT];
  logic signed [SUMW-1:0] sum_p [LAT-1];
  logic [16:0]        amp_p [LAT-1];
  logic [16:0]        gx_p [4];
  logic [16:0]        gz_p [5];

  logic [31:0]        n1 [4];
  logic [31:0]        n2 [4];
  logic [31:0]        n3 [4];
  logic [31:0]        sq [4];
  logic [31:0]        t2 [4];
  logic [31:0]        mh [4];
  logic signed [18:0] cv [4];
  logic signed [18:0] cv_next [4];

  logic signed [19:0] d1, d1b, i1, i2, vv, i1_next, i2_next, v_next;
  logic signed [20:0] d2;
  logic signed [37:0] p1, p1b, pv;
  logic signed [38:0] p2;
  logic [32:0]        ap;

  // cell index and fraction of this octave sit at fixed bit offsets
  assign qxe = EW'(qx_in);
  assign qze = EW'(qz_in);
  assign cxm = qxe[POS+16 +: 32];
  assign czm = qze[POS+16 +: 32];
  assign fx  = qxe[POS +: 16];
  assign fz  = qze[POS +: 16];
  assign cx  = ctl_in.sign_x ? (32'd0 - cxm) : cxm;
  assign cz  = ctl_in.sign_z ? (32'd0 - czm) : czm;
  assign base = cx + cz * vng_pkg::HASH_Z_MUL + seed;

  // corners (cx,cz) (cx+1,cz) (cx,cz+1) (cx+1,cz+1)
  assign nb[0] = base;
  assign nb[1] = base + 32'd1;
  assign nb[2] = base + vng_pkg::HASH_Z_MUL;
  assign nb[3] = base + vng_pkg::HASH_Z_MUL + 32'd1;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      nh[c] = nb[c] ^ (nb[c] << vng_pkg::HASH_SHIFT);
      mh[c] = (n3[c] * t2[c] + vng_pkg::HASH_ADD2) & vng_pkg::HASH_MASK;
      cv_next[c] = 19'sd65536 - $signed({2'b00, mh[c][30:14]});
    end
    d1  = 20'(cv[1]) - 20'(cv[0]);
    d1b = 20'(cv[3]) - 20'(cv[2]);
    p1  = d1 * $signed({1'b0, gx_p[3]});
    p1b = d1b * $signed({1'b0, gx_p[3]});
    i1_next = 20'(cv[0]) + 20'(p1 >>> 16);
    i2_next = 20'(cv[2]) + 20'(p1b >>> 16);
    d2 = 21'(i2) - 21'(i1);
    p2 = d2 * $signed({1'b0, gz_p[4]});
    v_next = i1 + 20'(p2 >>> 16);
    pv = vv * $signed({1'b0, amp_p[5]});
    ap = amp_p[5] * roughness_q16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) ctl_p[k] <= '0;
    end else if (adv) begin
      ctl_p[0] <= ctl_in;
      for (int k = 1; k < LAT; k++) ctl_p[k] <= ctl_p[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qx_p[0]  <= qx_in;
      qz_p[0]  <= qz_in;
      sum_p[0] <= sum_in;
      amp_p[0] <= amp_in;
      gx_p[0]  <= wtab[fx[15 -: TBITS]];
      gz_p[0]  <= wtab[fz[15 -: TBITS]];
      for (int k = 1; k < LAT; k++) begin
        qx_p[k] <= qx_p[k-1];
        qz_p[k] <= qz_p[k-1];
      end
      for (int k = 1; k < LAT - 1; k++) begin
        sum_p[k] <= sum_p[k-1];
        amp_p[k] <= amp_p[k-1];
      end
      for (int k = 1; k < 4; k++) gx_p[k] <= gx_p[k-1];
      for (int k = 1; k < 5; k++) gz_p[k] <= gz_p[k-1];
      for (int c = 0; c < 4; c++) begin
        n1[c] <= nh[c];
        sq[c] <= n1[c] * n1[c];
        n2[c] <= n1[c];
        t2[c] <= sq[c] * vng_pkg::HASH_MUL + vng_pkg::HASH_ADD1;
        n3[c] <= n2[c];
        cv[c] <= cv_next[c];
      end
      i1 <= i1_next;
      i2 <= i2_next;
      vv <= v_next;
      sum_out <= active ? (sum_p[5] + SUMW'(pv >>> 16)) : sum_p[5];
      amp_out <= ap[32:16];
    end
  end

  assign ctl_out = ctl_p[LAT-1];
  assign qx_out  = qx_p[LAT-1];
  assign qz_out  = qz_p[LAT-1];
endmodule

[tb/tb_value_noise_height_generator_core.sv]
// Testbench for the value noise height generator: scoreboard, drivers, phases
`timescale 1ns / 1ps
module tb_value_noise_height_generator_core;

  localparam int CHUNK_SIZE = 16;
  localparam int OCT_MAX    = 16;
  localparam int TAB_BITS   = 8;
  localparam int TAB_N      = 1 << TAB_BITS;
  localparam int DRAIN_CYCLES = 200;

  class height_scoreboard;
    bit [31:0]          seed;
    bit [4:0]           octave_count;
    bit [15:0]          gain;
    bit [15:0]          smooth;
    bit signed [15:0]   offset;
    bit [15:0]          rough;
    bit [16:0]          weight_tab [TAB_N];
    logic signed [23:0] height_q [$];
    int                 errors;

    function new();
      longint unsigned theta, th2, term;
      longint c;
      longint unsigned w;
      seed = 0; octave_count = 7; gain = 200; smooth = 128; offset = 3; rough = 34734;
      errors = 0;
      for (int i = 0; i <= TAB_N / 2; i++) begin
        theta = (64'd3373259426 * longint'(i)) >> TAB_BITS;
        th2 = (theta * theta) >> 30;
        term = 64'd1073741824;
        c = 64'sd1073741824;
        for (int k = 1; k <= 10; k++) begin
          term = ((term * th2) >> 30) / longint'((2 * k - 1) * (2 * k));
          if (k % 2 == 1) c = c - longint'(term);
          else c = c + longint'(term);
        end
        c = 64'sd1073741824 - c;
        if (c < 0) c = 0;
        w = (longint'(c) + 16384) >> 15;
        if (w > 32768) w = 32768;
        weight_tab[i] = 17'(w);
      end
      for (int i = TAB_N / 2 + 1; i < TAB_N; i++)
        weight_tab[i] = 17'd65536 - weight_tab[TAB_N - i];
    endfunction

    function void set_reg(vng_pkg::reg_idx_t idx, bit [31:0] val);
      case (idx)
        vng_pkg::REG_SEED:    seed = val;
        vng_pkg::REG_OCTAVES: octave_count = val[4:0];
        vng_pkg::REG_GAIN:    gain = val[15:0];
        vng_pkg::REG_SMOOTH:  smooth = val[15:0];
        vng_pkg::REG_OFFSET:  offset = val[15:0];
        vng_pkg::REG_ROUGH:   rough = val[15:0];
        default: ;
      endcase
    endfunction

    function longint floor_div(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
    endfunction

    function longint lattice(bit [31:0] cx, bit [31:0] cz);
      bit [31:0] n, m;
      n = cx + cz * 32'd57 + seed;
      n = (n << 13) ^ n;
      m = (n * (n * n * 32'd60493 + 32'd19990303) + 32'd1376312589) & 32'h7fffffff;
      return 65536 - longint'(m >> 14);
    endfunction

    function longint lerp(longint a, longint b, bit [16:0] w);
      return a + floor_div((b - a) * longint'(w), 65536);
    endfunction

    function void cell_split(longint w, int oct, longint unsigned sm,
                             output bit [31:0] cell_idx, output bit [31:0] frac);
      longint unsigned mag, q, r;
      mag = longint'(w < 0 ? -w : w) << oct;
      q = mag / sm;
      r = mag % sm;
      frac = 32'((r * 65536) / sm);
      cell_idx = (w < 0) ? 32'(-q) : 32'(q);
    endfunction

    function void note_coord(bit [3:0] lx, bit [3:0] lz,
                             bit signed [20:0] chx, bit signed [20:0] chz);
      longint wx, wz, sum, h, v, i1, i2;
      longint unsigned sm;
      bit [31:0] cx, cz, fx, fz, amp;
      bit [16:0] gx, gz;
      int n;
      wx = longint'(lx) + longint'(chx) * CHUNK_SIZE;
      wz = longint'(lz) + longint'(chz) * CHUNK_SIZE;
      sm = (smooth == 0) ? 1 : smooth;
      n = (octave_count > OCT_MAX) ? OCT_MAX : octave_count;
      n = (n != 0) ? n - 1 : 0;
      sum = 0;
      amp = 65536;
      for (int oct = 0; oct < n; oct++) begin
        cell_split(wx, oct, sm, cx, fx);
        cell_split(wz, oct, sm, cz, fz);
        gx = weight_tab[(fx >> (16 - TAB_BITS)) & (TAB_N - 1)];
        gz = weight_tab[(fz >> (16 - TAB_BITS)) & (TAB_N - 1)];
        i1 = lerp(lattice(cx, cz), lattice(cx + 1, cz), gx);
        i2 = lerp(lattice(cx, cz + 1), lattice(cx + 1, cz + 1), gx);
        v = lerp(i1, i2, gz);
        sum += floor_div(v * longint'(amp), 65536);
        amp = 32'((longint'(amp) * longint'(rough)) >> 16);
      end
      h = floor_div((sum * 50 + 8257536) * longint'(gain), 26880) + longint'(offset) * 256;
      if (h > 8388607) h = 8388607;
      if (h < -8388608) h = -8388608;
      height_q.push_back(24'(h));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_height(logic signed [23:0] got);
      logic signed [23:0] want;
      if (height_q.size() == 0) begin
        report_mismatch($sformatf("unexpected height %0d", got));
        return;
      end
      want = height_q.pop_front();
      if (got !== want)
        report_mismatch($sformatf("height_q8 got %0d want %0d", got, want));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          send_idle_pct;
  int          recv_stall_pct;
  height_scoreboard sb;

  vng_in_if  coord_ch ();
  vng_out_if result_ch ();

  value_noise_height_generator_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .coord    (coord_ch.sink),
    .result   (result_ch.source)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // accepted requests and results, sampled at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (coord_ch.valid && coord_ch.ready)
        sb.note_coord(coord_ch.local_x, coord_ch.local_z, coord_ch.chunk_x, coord_ch.chunk_z);
      if (result_ch.valid && result_ch.ready)
        sb.check_height(result_ch.height_q8);
    end
  end

  task automatic send_coord(bit [3:0] lx, bit [3:0] lz, bit [20:0] chx, bit [20:0] chz);
    while ($urandom_range(99) < send_idle_pct) begin
      coord_ch.valid <= 1'b0;
      @(posedge clk);
    end
    coord_ch.valid   <= 1'b1;
    coord_ch.local_x <= lx;
    coord_ch.local_z <= lz;
    coord_ch.chunk_x <= chx;
    coord_ch.chunk_z <= chz;
    do @(posedge clk); while (!coord_ch.ready);
  endtask

  task automatic wait_idle();
    coord_ch.valid <= 1'b0;
    while (sb.height_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(bit [31:0] sd, bit [4:0] oc, bit [15:0] gn, bit [15:0] sm,
                           bit [15:0] ofs, bit [15:0] rg);
    bit [31:0]         vals [6];
    vng_pkg::reg_idx_t idx [6];
    vals = '{sd, 32'(oc), 32'(gn), 32'(sm), 32'(ofs), 32'(rg)};
    idx = '{vng_pkg::REG_SEED, vng_pkg::REG_OCTAVES, vng_pkg::REG_GAIN,
            vng_pkg::REG_SMOOTH, vng_pkg::REG_OFFSET, vng_pkg::REG_ROUGH};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      sb.set_reg(idx[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [20:0] pick_chunk();
    case ($urandom_range(5))
      0, 1: return 21'($urandom);
      2: return $urandom_range(1) ? 21'h0fffff : 21'h100000;
      default: return 21'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    coord_ch.valid = 1'b0;
    coord_ch.local_x = '0;
    coord_ch.local_z = '0;
    coord_ch.chunk_x = '0;
    coord_ch.chunk_z = '0;
    result_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and negative coordinates at reset settings
    send_coord(4'd0, 4'd0, 21'd0, 21'd0);
    send_coord(4'd15, 4'd15, 21'd0, 21'd0);
    send_coord(4'd15, 4'd0, 21'h0fffff, 21'h100000);
    send_coord(4'd0, 4'd15, 21'h100000, 21'h0fffff);
    send_coord(4'd7, 4'd9, 21'h1fffff, 21'h1fffff);
    send_coord(4'd15, 4'd15, 21'h100000, 21'h100000);
    send_coord(4'd3, 4'd12, 21'h0fffff, 21'h0fffff);
    wait_idle();
    // saturation high, many octaves, smallest divisor, large cell indices
    write_all(32'hffffffff, 5'd16, 16'hffff, 16'd1, 16'h7fff, 16'hffff);
    send_coord(4'd15, 4'd15, 21'h0fffff, 21'h100000);
    send_coord(4'd1, 4'd2, 21'h1ffffe, 21'd3);
    wait_idle();
    write_all(32'd0, 5'd31, 16'hffff, 16'd1, 16'h8000, 16'hffff);
    send_coord(4'd0, 4'd0, 21'h100000, 21'h100000);
    send_coord(4'd8, 4'd8, 21'd5, 21'h1ffff0);
    wait_idle();
    // no octaves, zero divisor, zero roughness
    write_all(32'h12345678, 5'd0, 16'd0, 16'd0, 16'h8000, 16'd0);
    send_coord(4'd4, 4'd5, 21'd6, 21'd7);
    wait_idle();
    write_all(32'h9abcdef0, 5'd1, 16'd500, 16'hffff, 16'h7fff, 16'd0);
    send_coord(4'd4, 4'd5, 21'h1fff00, 21'd7);
    wait_idle();
    write_all(32'h0, 5'd3, 16'd300, 16'd0, 16'hfffd, 16'd40000);
    send_coord(4'd9, 4'd2, 21'h1ffffd, 21'd2);
    send_coord(4'd15, 4'd0, 21'd1, 21'h1fffff);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      set_idling(ph % 4);
      write_all($urandom, 5'($urandom_range(ph == 3 ? 31 : 17)), 16'($urandom),
                ph < 4 ? 16'($urandom_range(1, 400)) : 16'($urandom),
                16'($urandom), 16'($urandom));
      for (int i = 0; i < 95; i++)
        send_coord(4'($urandom), 4'($urandom), pick_chunk(), pick_chunk());
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/vng_pkg.sv
hw/rtl/vng_in_if.sv
hw/rtl/vng_out_if.sv
hw/rtl/vng_div_cell.sv
hw/rtl/vng_oct_cell.sv
hw/rtl/value_noise_height_generator_core.sv
tb/tb_value_noise_height_generator_core.sv
